FILE: hdl/rfa_pkg.sv
package rfa_pkg;

	localparam int MAX_PARTICLES = 256;
	localparam int MAX_ALPHAS = 8;
	localparam int NUM_ROWS = 3;
	localparam int PART_W = 8;
	localparam int COL_W = 3;
	localparam int ACC_DEPTH = MAX_PARTICLES * MAX_ALPHAS;
	localparam int ACC_W = 65;
	localparam int INFO_W = 12;
	localparam int TAYLOR_TERMS = 12;

	localparam logic [2:0] MODE_INFO = 3'd0;
	localparam logic [2:0] MODE_ALPHA = 3'd1;
	localparam logic [2:0] MODE_WEIGHT = 3'd2;
	localparam logic [2:0] MODE_PARTNER = 3'd3;
	localparam logic [2:0] MODE_PAIR = 3'd4;
	localparam logic [2:0] MODE_READ = 3'd5;

	localparam logic [1:0] ROW_SAME_MOL = 2'd0;
	localparam logic [1:0] ROW_OTHER = 2'd1;
	localparam logic [1:0] ROW_PARTNER = 2'd2;
	localparam logic [1:0] ROW_INVALID = 2'd3;

	localparam logic [3:0] ALPHA_COUNT_RESET = 4'd8;
	localparam logic [3:0] ALPHA_COUNT_MAX = 4'd8;

	// ln2 in Q.30 and its scaled reciprocal for the range reduction
	localparam longint LN2_Q30 = 744261118;
	localparam logic [20:0] K_RECIP = 21'(((64'd1) << 50) / LN2_Q30);
	localparam int K_SHIFT = 50;
	localparam logic [28:0] ARG_LIMIT_Q24 = 29'd1 << 28;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NB_RD,
		ST_ROW,
		ST_ARG,
		ST_XQ,
		ST_KEST,
		ST_KMUL,
		ST_KFIX,
		ST_TMUL,
		ST_TDIV,
		ST_TFIX,
		ST_SHIFT,
		ST_P1A,
		ST_P1B,
		ST_P2A,
		ST_P2B,
		ST_ACC_RD,
		ST_ACC,
		ST_RD_ISSUE,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] particle_index;
		logic [7:0] neighbor_index;
		logic [5:0] pair_slot;
		logic [6:0] neighbor_total;
		logic [31:0] descriptor;
		logic [7:0] molecule_id;
		logic [3:0] color;
		logic [3:0] partner_color;
		logic [1:0] row;
		logic [2:0] alpha_index;
		logic signed [31:0] coefficient_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0] result_alpha;
		logic signed [63:0] fingerprint_value;
		logic saturated;
		logic last;
	} result_t;

	// floor(2^32 / n) for the Taylor divide by n
	function automatic logic [32:0] taylor_recip(input logic [3:0] n);
		logic [32:0] r;
		unique case (n)
			4'd1: r = 33'((64'd1 << 32) / 1);
			4'd2: r = 33'((64'd1 << 32) / 2);
			4'd3: r = 33'((64'd1 << 32) / 3);
			4'd4: r = 33'((64'd1 << 32) / 4);
			4'd5: r = 33'((64'd1 << 32) / 5);
			4'd6: r = 33'((64'd1 << 32) / 6);
			4'd7: r = 33'((64'd1 << 32) / 7);
			4'd8: r = 33'((64'd1 << 32) / 8);
			4'd9: r = 33'((64'd1 << 32) / 9);
			4'd10: r = 33'((64'd1 << 32) / 10);
			4'd11: r = 33'((64'd1 << 32) / 11);
			4'd12: r = 33'((64'd1 << 32) / 12);
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/rfa_ram.sv
module rfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/radial_fingerprint_accumulator_core.sv
// Radial fingerprint accumulator.
// Command channel: cmd is taken at a clock edge with start high and busy low.
// Table loads (particle info, alpha, weight, color partner) complete in idle.
// A pair transaction whose slot lies inside the neighbor list reads both
// particles' info from the info RAM (NB_RD, ROW), then walks all 8 alpha
// columns. Each active column runs the exp/multiply sequence (a 12-step
// Taylor loop through TMUL, TDIV and TFIX, using separate multiply,
// reciprocal-multiply and remainder logic) and then the read-modify-write
// of the accumulator RAM in ACC_RD and ACC. An inactive column only passes
// through ACC_RD and ACC to rewrite its entry. busy stays high until the
// last column is written back. Pairs outside the list leave the block idle.
// A read-clear transaction emits alpha_count results (0 counts as 1, above 8
// as 8), each shown for one cycle with done high; last marks the final one.
// The receiver cannot stall; results must be taken when done is high.
// Reset clears a per-particle valid bit (no clearing pass): an invalid
// particle's accumulators read as zero. alpha_count resets to 8. The user
// must write it through cfg_we/cfg_wdata while the block is idle (unchecked).
module radial_fingerprint_accumulator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rfa_pkg::cmd_t     cmd,
	output logic              done,
	output rfa_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata
);

	rfa_pkg::state_t state_q, state_d;
	rfa_pkg::cmd_t it_q;

	logic [3:0] alpha_count_q;
	logic [3:0] cnt;
	logic [2:0] col_q;
	logic [rfa_pkg::MAX_PARTICLES-1:0] valid_q;

	logic [31:0] alpha_tab [rfa_pkg::NUM_ROWS * rfa_pkg::MAX_ALPHAS];
	logic [31:0] weight_tab [rfa_pkg::NUM_ROWS * rfa_pkg::MAX_ALPHAS];
	logic [3:0] partner_tab [16];

	logic info_we;
	logic [rfa_pkg::PART_W-1:0] info_raddr;
	logic [rfa_pkg::INFO_W-1:0] info_rdata;

	logic acc_we;
	logic [rfa_pkg::PART_W+rfa_pkg::COL_W-1:0] acc_addr;
	logic [rfa_pkg::ACC_W-1:0] acc_wdata, acc_rdata;

	logic [7:0] mol_p_q;
	logic [3:0] colp_q;
	logic [1:0] row_q;

	logic a_neg_q, w_neg_q;
	logic [31:0] w_mag_q;
	logic [63:0] prod_s1;
	logic signed [35:0] x30_q;
	logic signed [7:0] k_q;
	logic signed [36:0] r0_q;
	logic [29:0] r_q;
	logic [30:0] term_q, v_q, qd_q;
	logic [31:0] sum_q;
	logic [3:0] n_q;
	logic [54:0] e_q;
	logic [59:0] pa_q;
	logic [56:0] p1_q;
	logic [60:0] qa_q;
	logic signed [63:0] tv_q;
	logic tsat_q;

	// combinational datapath values
	logic pair_ok;
	logic [4:0] tab_idx;
	logic [31:0] a_raw, w_raw, a_mag, w_mag;
	logic [63:0] q_round;
	logic [33:0] q34;
	logic [34:0] xmag;
	logic signed [57:0] kp;
	logic signed [36:0] ln2_s;
	logic signed [7:0] k_neg;
	logic [60:0] tprod;
	logic [63:0] dprod;
	logic [34:0] rem;
	logic [58:0] pb;
	logic [87:0] p1_full;
	logic [59:0] qb;
	logic [88:0] p2_full;
	logic [64:0] p2;
	logic [63:0] p2c;
	logic signed [63:0] acc_old;
	logic sat_old;
	logic signed [64:0] acc_sum;
	logic signed [63:0] acc_new;
	logic add_sat;
	logic col_last, rd_last;

	rfa_ram #(.WIDTH(rfa_pkg::INFO_W), .DEPTH(rfa_pkg::MAX_PARTICLES)) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (cmd.particle_index),
		.wdata ({cmd.molecule_id, cmd.color}),
		.raddr (info_raddr),
		.rdata (info_rdata)
	);

	rfa_ram #(.WIDTH(rfa_pkg::ACC_W), .DEPTH(rfa_pkg::ACC_DEPTH)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_addr),
		.wdata (acc_wdata),
		.raddr (acc_addr),
		.rdata (acc_rdata)
	);

	always_comb begin
		if (alpha_count_q == 4'd0) begin
			cnt = 4'd1;
		end else if (alpha_count_q > rfa_pkg::ALPHA_COUNT_MAX) begin
			cnt = rfa_pkg::ALPHA_COUNT_MAX;
		end else begin
			cnt = alpha_count_q;
		end
	end

	assign pair_ok = {1'b0, cmd.pair_slot} < cmd.neighbor_total;
	assign tab_idx = {row_q, col_q};
	assign acc_addr = {it_q.particle_index, col_q};
	assign col_last = (col_q == 3'(rfa_pkg::MAX_ALPHAS - 1));
	assign rd_last = ({1'b0, col_q} == cnt - 4'd1);
	assign busy = (state_q != rfa_pkg::ST_IDLE);

	// arithmetic helpers
	always_comb begin
		a_raw = alpha_tab[tab_idx];
		w_raw = weight_tab[tab_idx];
		a_mag = a_raw[31] ? (~a_raw + 32'd1) : a_raw;
		w_mag = w_raw[31] ? (~w_raw + 32'd1) : w_raw;

		// negative arguments round the magnitude up, i.e. floor of the signed value
		q_round = a_neg_q ? (prod_s1 + 64'h3FFF_FFFF) : prod_s1;
		q34 = 34'(q_round >> 30);
		if (q34 > 34'(rfa_pkg::ARG_LIMIT_Q24)) begin
			xmag = {6'd0, rfa_pkg::ARG_LIMIT_Q24} << 6;
		end else begin
			xmag = {q34[28:0], 6'd0};
		end

		kp = x30_q * $signed({1'b0, rfa_pkg::K_RECIP});
		ln2_s = 37'(rfa_pkg::LN2_Q30);
		k_neg = -k_q;

		tprod = 61'(term_q) * 61'(r_q);
		dprod = 64'(v_q) * 64'(rfa_pkg::taylor_recip(n_q));
		rem = 35'(v_q) - 35'(qd_q) * 35'(n_q);

		pb = 59'(it_q.descriptor) * 59'(e_q[54:28]);
		p1_full = 88'(pa_q) + (88'(pb) << 28);

		qb = 60'(p1_q[56:29]) * 60'(w_mag_q);
		p2_full = 89'(qa_q) + (89'(qb) << 29);
		p2 = 65'(p2_full >> 24);
		p2c = (p2[64:63] != 2'b00) ? {1'b0, {63{1'b1}}} : p2[63:0];

		acc_old = valid_q[it_q.particle_index] ? $signed(acc_rdata[63:0]) : 64'sd0;
		sat_old = valid_q[it_q.particle_index] ? acc_rdata[64] : 1'b0;
		acc_sum = 65'(acc_old) + 65'(tv_q);
		add_sat = (acc_sum[64] != acc_sum[63]);
		if (!add_sat) begin
			acc_new = acc_sum[63:0];
		end else if (acc_sum[64]) begin
			acc_new = {1'b1, 63'd0};
		end else begin
			acc_new = {1'b0, {63{1'b1}}};
		end
		acc_wdata = {sat_old | tsat_q | add_sat, acc_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		info_we = 1'b0;
		info_raddr = it_q.particle_index;
		acc_we = 1'b0;
		done = 1'b0;
		result.result_alpha = col_q;
		result.fingerprint_value = acc_old;
		result.saturated = sat_old;
		result.last = rd_last;
		unique case (state_q)
			rfa_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.mode == rfa_pkg::MODE_INFO) begin
						info_we = 1'b1;
					end else if (cmd.mode == rfa_pkg::MODE_PAIR && pair_ok) begin
						info_raddr = cmd.particle_index;
						state_d = rfa_pkg::ST_NB_RD;
					end else if (cmd.mode == rfa_pkg::MODE_READ) begin
						state_d = rfa_pkg::ST_RD_ISSUE;
					end
				end
			end
			rfa_pkg::ST_NB_RD: begin
				info_raddr = it_q.neighbor_index;
				state_d = rfa_pkg::ST_ROW;
			end
			rfa_pkg::ST_ROW: state_d = rfa_pkg::ST_ARG;
			rfa_pkg::ST_ARG: begin
				// inactive columns still rewrite the entry so the row becomes valid
				state_d = ({1'b0, col_q} >= cnt) ? rfa_pkg::ST_ACC_RD : rfa_pkg::ST_XQ;
			end
			rfa_pkg::ST_XQ: state_d = rfa_pkg::ST_KEST;
			rfa_pkg::ST_KEST: state_d = rfa_pkg::ST_KMUL;
			rfa_pkg::ST_KMUL: state_d = rfa_pkg::ST_KFIX;
			rfa_pkg::ST_KFIX: state_d = rfa_pkg::ST_TMUL;
			rfa_pkg::ST_TMUL: state_d = rfa_pkg::ST_TDIV;
			rfa_pkg::ST_TDIV: state_d = rfa_pkg::ST_TFIX;
			rfa_pkg::ST_TFIX: begin
				state_d = (n_q == 4'(rfa_pkg::TAYLOR_TERMS)) ? rfa_pkg::ST_SHIFT
					: rfa_pkg::ST_TMUL;
			end
			rfa_pkg::ST_SHIFT: state_d = rfa_pkg::ST_P1A;
			rfa_pkg::ST_P1A: state_d = rfa_pkg::ST_P1B;
			rfa_pkg::ST_P1B: state_d = rfa_pkg::ST_P2A;
			rfa_pkg::ST_P2A: state_d = rfa_pkg::ST_P2B;
			rfa_pkg::ST_P2B: state_d = rfa_pkg::ST_ACC_RD;
			rfa_pkg::ST_ACC_RD: state_d = rfa_pkg::ST_ACC;
			rfa_pkg::ST_ACC: begin
				acc_we = 1'b1;
				state_d = col_last ? rfa_pkg::ST_IDLE : rfa_pkg::ST_ARG;
			end
			rfa_pkg::ST_RD_ISSUE: state_d = rfa_pkg::ST_RD_OUT;
			rfa_pkg::ST_RD_OUT: begin
				done = 1'b1;
				state_d = rd_last ? rfa_pkg::ST_IDLE : rfa_pkg::ST_RD_ISSUE;
			end
			default: state_d = rfa_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_count_q <= rfa_pkg::ALPHA_COUNT_RESET;
			valid_q <= '0;
			col_q <= '0;
			n_q <= 4'd1;
		end else begin
			if (cfg_we) begin
				alpha_count_q <= cfg_wdata;
			end
			unique case (state_q)
				rfa_pkg::ST_IDLE: col_q <= '0;
				rfa_pkg::ST_KFIX: n_q <= 4'd1;
				rfa_pkg::ST_TFIX: n_q <= n_q + 4'd1;
				rfa_pkg::ST_ACC: begin
					col_q <= col_q + 3'd1;
					if (col_last) begin
						valid_q[it_q.particle_index] <= 1'b1;
					end
				end
				rfa_pkg::ST_RD_OUT: begin
					col_q <= col_q + 3'd1;
					if (rd_last) begin
						valid_q[it_q.particle_index] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// tables and datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			rfa_pkg::ST_IDLE: begin
				if (start) begin
					it_q <= cmd;
					if (cmd.mode == rfa_pkg::MODE_ALPHA && cmd.row != rfa_pkg::ROW_INVALID) begin
						alpha_tab[{cmd.row, cmd.alpha_index}] <= cmd.coefficient_value;
					end
					if (cmd.mode == rfa_pkg::MODE_WEIGHT && cmd.row != rfa_pkg::ROW_INVALID) begin
						weight_tab[{cmd.row, cmd.alpha_index}] <= cmd.coefficient_value;
					end
					if (cmd.mode == rfa_pkg::MODE_PARTNER) begin
						partner_tab[cmd.color] <= cmd.partner_color;
					end
				end
			end
			rfa_pkg::ST_NB_RD: begin
				mol_p_q <= info_rdata[11:4];
				colp_q <= info_rdata[3:0];
			end
			rfa_pkg::ST_ROW: begin
				if (mol_p_q == info_rdata[11:4]) begin
					row_q <= rfa_pkg::ROW_SAME_MOL;
				end else if (partner_tab[colp_q] == info_rdata[3:0]) begin
					row_q <= rfa_pkg::ROW_PARTNER;
				end else begin
					row_q <= rfa_pkg::ROW_OTHER;
				end
			end
			rfa_pkg::ST_ARG: begin
				a_neg_q <= a_raw[31];
				w_neg_q <= w_raw[31];
				w_mag_q <= w_mag;
				prod_s1 <= 64'(a_mag) * 64'(it_q.descriptor);
				tv_q <= '0;
				tsat_q <= 1'b0;
			end
			rfa_pkg::ST_XQ: begin
				x30_q <= a_neg_q ? -$signed({1'b0, xmag}) : $signed({1'b0, xmag});
			end
			rfa_pkg::ST_KEST: k_q <= kp[57:50];
			rfa_pkg::ST_KMUL: r0_q <= 37'(x30_q) - 37'(k_q) * ln2_s;
			rfa_pkg::ST_KFIX: begin
				if (r0_q < 0) begin
					r_q <= 30'(r0_q + ln2_s);
					k_q <= k_q - 8'sd1;
				end else if (r0_q >= ln2_s) begin
					r_q <= 30'(r0_q - ln2_s);
					k_q <= k_q + 8'sd1;
				end else begin
					r_q <= 30'(r0_q);
				end
				term_q <= 31'd1 << 30;
				sum_q <= 32'd1 << 30;
			end
			rfa_pkg::ST_TMUL: v_q <= 31'(tprod >> 30);
			rfa_pkg::ST_TDIV: qd_q <= 31'(dprod >> 32);
			rfa_pkg::ST_TFIX: begin
				if (rem >= 35'(n_q)) begin
					term_q <= qd_q + 31'd1;
					sum_q <= sum_q + 32'(qd_q) + 32'd1;
				end else begin
					term_q <= qd_q;
					sum_q <= sum_q + 32'(qd_q);
				end
			end
			rfa_pkg::ST_SHIFT: begin
				if (k_q >= 0) begin
					e_q <= 55'(sum_q) << k_q[4:0];
				end else begin
					e_q <= 55'(sum_q) >> k_neg[4:0];
				end
			end
			rfa_pkg::ST_P1A: pa_q <= 60'(it_q.descriptor) * 60'(e_q[27:0]);
			rfa_pkg::ST_P1B: p1_q <= 57'(p1_full >> 30);
			rfa_pkg::ST_P2A: qa_q <= 61'(p1_q[28:0]) * 61'(w_mag_q);
			rfa_pkg::ST_P2B: begin
				tv_q <= w_neg_q ? -$signed(p2c) : $signed(p2c);
				tsat_q <= (p2[64:63] != 2'b00);
			end
			default: ;
		endcase
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 600;
	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	// modes the block does not define
	localparam logic [2:0] MODE_UNKNOWN_A = 3'd6;
	localparam logic [2:0] MODE_UNKNOWN_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	rfa_pkg::cmd_t cmd;
	logic done;
	rfa_pkg::result_t result;
	logic cfg_we;
	logic [3:0] cfg_wdata;

	radial_fingerprint_accumulator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the block state
	logic [3:0] alpha_count_reg;
	logic [7:0] mol_tab [rfa_pkg::MAX_PARTICLES];
	logic [3:0] color_tab [rfa_pkg::MAX_PARTICLES];
	logic [3:0] partner_tab [16];
	bit partner_ok [16];
	logic [31:0] alpha_tab [rfa_pkg::NUM_ROWS*rfa_pkg::MAX_ALPHAS];
	logic [31:0] weight_tab [rfa_pkg::NUM_ROWS*rfa_pkg::MAX_ALPHAS];
	longint acc_tab [rfa_pkg::ACC_DEPTH];
	bit sat_tab [rfa_pkg::ACC_DEPTH];

	rfa_pkg::result_t fingerprint_q [$];
	int mismatches = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit burst = 0;

	function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
			input int s, inout bit ovf);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		if ((p >> (64 + s)) != 0) begin
			ovf = 1'b1;
			return '1;
		end
		return 64'(p >> s);
	endfunction

	function automatic logic [63:0] exp_q30(input longint x24);
		longint x30, k, r;
		logic [63:0] t, sum;
		x30 = x24 * 64;
		k = x30 / rfa_pkg::LN2_Q30;
		r = x30 - k * rfa_pkg::LN2_Q30;
		if (r < 0) begin
			k = k - 1;
			r = r + rfa_pkg::LN2_Q30;
		end
		t = 64'd1 << 30;
		sum = t;
		for (int n = 1; n <= rfa_pkg::TAYLOR_TERMS; n++) begin
			t = ((t * 64'(r)) >> 30) / 64'(n);
			sum = sum + t;
		end
		return (k >= 0) ? (sum << k) : (sum >> (-k));
	endfunction

	function automatic void add_term(input int slot, input logic [31:0] d,
			input logic [31:0] a_raw, input logic [31:0] w_raw);
		logic [63:0] a_mag, w_mag, prod, q, e, p1, p2;
		longint a_s, w_s, x24, term;
		logic signed [64:0] sum;
		bit sat;
		sat = 1'b0;
		a_s = longint'($signed(a_raw));
		w_s = longint'($signed(w_raw));
		a_mag = a_raw[31] ? -a_s : a_s;
		w_mag = w_raw[31] ? -w_s : w_s;
		prod = a_mag * {32'd0, d};
		q = a_raw[31] ? (prod + (64'd1 << 30) - 64'd1) >> 30 : prod >> 30;
		if (q > (64'd16 << 24))
			q = 64'd16 << 24;
		x24 = a_raw[31] ? -longint'(q) : longint'(q);
		e = exp_q30(x24);
		p1 = mul_shr({32'd0, d}, e, 30, sat);
		p2 = mul_shr(p1, w_mag, 24, sat);
		if (p2 > POS_MAX) begin
			p2 = POS_MAX;
			sat = 1'b1;
		end
		term = w_raw[31] ? -longint'(p2) : longint'(p2);
		sum = acc_tab[slot] + term;
		if (sum[64] != sum[63]) begin
			sat = 1'b1;
			acc_tab[slot] = sum[64] ? longint'({1'b1, 63'd0}) : longint'(POS_MAX);
		end else begin
			acc_tab[slot] = sum[63:0];
		end
		if (sat)
			sat_tab[slot] = 1'b1;
	endfunction

	function automatic int active_columns();
		if (alpha_count_reg < 1)
			return 1;
		if (alpha_count_reg > rfa_pkg::MAX_ALPHAS)
			return rfa_pkg::MAX_ALPHAS;
		return alpha_count_reg;
	endfunction

	function automatic void predict_fingerprint(input rfa_pkg::cmd_t c);
		int cnt, total, base;
		logic [1:0] r;
		rfa_pkg::result_t res;
		cnt = active_columns();
		base = c.particle_index * rfa_pkg::MAX_ALPHAS;
		case (c.mode)
			rfa_pkg::MODE_INFO: begin
				mol_tab[c.particle_index] = c.molecule_id;
				color_tab[c.particle_index] = c.color;
			end
			rfa_pkg::MODE_ALPHA, rfa_pkg::MODE_WEIGHT: begin
				if (c.row != rfa_pkg::ROW_INVALID) begin
					if (c.mode == rfa_pkg::MODE_ALPHA)
						alpha_tab[c.row*rfa_pkg::MAX_ALPHAS + c.alpha_index] =
							c.coefficient_value;
					else
						weight_tab[c.row*rfa_pkg::MAX_ALPHAS + c.alpha_index] =
							c.coefficient_value;
				end
			end
			rfa_pkg::MODE_PARTNER: begin
				partner_tab[c.color] = c.partner_color;
				partner_ok[c.color] = 1'b1;
			end
			rfa_pkg::MODE_PAIR: begin
				total = (c.neighbor_total > 64) ? 64 : c.neighbor_total;
				if (c.pair_slot < total) begin
					if (mol_tab[c.particle_index] == mol_tab[c.neighbor_index])
						r = rfa_pkg::ROW_SAME_MOL;
					else if (partner_tab[color_tab[c.particle_index]] ==
							color_tab[c.neighbor_index])
						r = rfa_pkg::ROW_PARTNER;
					else
						r = rfa_pkg::ROW_OTHER;
					for (int i = 0; i < cnt; i++)
						add_term(base + i, c.descriptor,
							alpha_tab[r*rfa_pkg::MAX_ALPHAS + i],
							weight_tab[r*rfa_pkg::MAX_ALPHAS + i]);
				end
			end
			rfa_pkg::MODE_READ: begin
				for (int i = 0; i < cnt; i++) begin
					res.result_alpha = 3'(i);
					res.fingerprint_value = acc_tab[base + i];
					res.saturated = sat_tab[base + i];
					res.last = (i + 1 == cnt);
					fingerprint_q.push_back(res);
				end
				for (int i = 0; i < rfa_pkg::MAX_ALPHAS; i++) begin
					acc_tab[base + i] = 0;
					sat_tab[base + i] = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		rfa_pkg::result_t exp_res;
		if (arst_n && done) begin
			if (fingerprint_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result alpha=%0d value=%0d", result.result_alpha,
						result.fingerprint_value);
			end else begin
				exp_res = fingerprint_q.pop_front();
				if (result !== exp_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp alpha=%0d val=%0d sat=%0b last=%0b,",
							" got alpha=%0d val=%0d sat=%0b last=%0b"},
							exp_res.result_alpha, exp_res.fingerprint_value, exp_res.saturated,
							exp_res.last, result.result_alpha, result.fingerprint_value,
							result.saturated, result.last);
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_cmd(input rfa_pkg::cmd_t c);
		int gap;
		if ($urandom_range(0, 15) == 0)
			burst = !burst;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_fingerprint(c);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic rfa_pkg::cmd_t noise_cmd();
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		return bits[$bits(rfa_pkg::cmd_t)-1:0];
	endfunction

	task automatic write_info(input int p, input logic [7:0] mol, input logic [3:0] col);
		rfa_pkg::cmd_t c;
		c = noise_cmd();
		c.mode = rfa_pkg::MODE_INFO;
		c.particle_index = 8'(p);
		c.molecule_id = mol;
		c.color = col;
		send_cmd(c);
	endtask

	task automatic write_coef(input logic [2:0] mode, input logic [1:0] row, input int ai,
			input logic [31:0] v);
		rfa_pkg::cmd_t c;
		c = noise_cmd();
		c.mode = mode;
		c.row = row;
		c.alpha_index = 3'(ai);
		c.coefficient_value = v;
		send_cmd(c);
	endtask

	task automatic write_partner(input logic [3:0] col, input logic [3:0] pc);
		rfa_pkg::cmd_t c;
		c = noise_cmd();
		c.mode = rfa_pkg::MODE_PARTNER;
		c.color = col;
		c.partner_color = pc;
		send_cmd(c);
	endtask

	task automatic send_pair(input int p, input int nb, input int slot, input int total,
			input logic [31:0] d);
		rfa_pkg::cmd_t c;
		if (!partner_ok[color_tab[p]])
			write_partner(color_tab[p], 4'($urandom));
		c = noise_cmd();
		c.mode = rfa_pkg::MODE_PAIR;
		c.particle_index = 8'(p);
		c.neighbor_index = 8'(nb);
		c.pair_slot = 6'(slot);
		c.neighbor_total = 7'(total);
		c.descriptor = d;
		send_cmd(c);
	endtask

	task automatic read_clear(input int p);
		rfa_pkg::cmd_t c;
		c = noise_cmd();
		c.mode = rfa_pkg::MODE_READ;
		c.particle_index = 8'(p);
		send_cmd(c);
	endtask

	task automatic drain(input int cycles);
		start = 1'b0;
		while (fingerprint_q.size() != 0)
			@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic set_alpha_count(input logic [3:0] v);
		drain(DRAIN_CYCLES);
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		alpha_count_reg = v;
	endtask

	function automatic logic [31:0] rand_alpha();
		logic [31:0] v;
		v = $urandom_range(0, 32'h0400_0000);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic test_coefficients();
		for (int r = 0; r < rfa_pkg::NUM_ROWS; r++)
			for (int i = 0; i < rfa_pkg::MAX_ALPHAS; i++) begin
				write_coef(rfa_pkg::MODE_ALPHA, 2'(r), i, rand_alpha());
				write_coef(rfa_pkg::MODE_WEIGHT, 2'(r), i, $urandom);
			end
		// clamp and saturation corners
		write_coef(rfa_pkg::MODE_ALPHA, rfa_pkg::ROW_PARTNER, 0, 32'h7FFF_FFFF);
		write_coef(rfa_pkg::MODE_WEIGHT, rfa_pkg::ROW_PARTNER, 0, 32'h7FFF_FFFF);
		write_coef(rfa_pkg::MODE_ALPHA, rfa_pkg::ROW_OTHER, 1, 32'h8000_0000);
		write_coef(rfa_pkg::MODE_WEIGHT, rfa_pkg::ROW_OTHER, 1, 32'h8000_0000);
		write_coef(rfa_pkg::MODE_WEIGHT, rfa_pkg::ROW_SAME_MOL, 2, 32'h0);
	endtask

	task automatic test_directed();
		rfa_pkg::cmd_t c;
		write_info(0, 8'h00, 4'h0);
		write_info(255, 8'hFF, 4'hF);
		write_info(1, 8'h00, 4'h3);
		write_info(2, 8'h01, 4'hF);
		write_partner(4'h0, 4'hF);
		write_partner(4'hF, 4'h0);
		write_partner(4'h3, 4'h3);
		// invalid row write: ignored
		write_coef(rfa_pkg::MODE_ALPHA, rfa_pkg::ROW_INVALID, 7, $urandom);
		write_coef(rfa_pkg::MODE_WEIGHT, rfa_pkg::ROW_INVALID, 7, $urandom);
		// unknown modes
		c = noise_cmd();
		c.mode = MODE_UNKNOWN_A;
		send_cmd(c);
		c = noise_cmd();
		c.mode = MODE_UNKNOWN_B;
		send_cmd(c);
		send_pair(0, 1, 0, 1, 32'hFFFF_FFFF);    // same molecule
		send_pair(0, 2, 63, 127, 32'h0);         // total clamped, slot in range
		send_pair(0, 255, 5, 64, 32'hFFFF_FFFF); // partner color
		send_pair(1, 2, 0, 0, $urandom);         // empty list: ignored
		send_pair(1, 2, 10, 10, $urandom);       // slot at the end: ignored
		send_pair(255, 0, 1, 2, $urandom);
		send_pair(2, 0, 2, 3, $urandom);         // partner color
		read_clear(0);
		read_clear(0);
		read_clear(1);
		read_clear(2);
		read_clear(255);
		read_clear(77);                          // never touched
	endtask

	task automatic run_frames(input int n_items);
		int parts [$];
		int stop_at, np, p, nb, slot, total;
		logic [31:0] d;
		rfa_pkg::cmd_t c;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			parts.delete();
			np = $urandom_range(2, 6);
			for (int i = 0; i < np; i++) begin
				p = $urandom_range(0, 255);
				parts.push_back(p);
				write_info(p, ($urandom_range(0, 7) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 2)), 4'($urandom_range(0, 3)));
			end
			if ($urandom_range(0, 2) == 0)
				write_partner(4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)));
			repeat ($urandom_range(2, 8)) begin
				p = parts[$urandom_range(0, np - 1)];
				nb = parts[$urandom_range(0, np - 1)];
				slot = $urandom_range(0, 63);
				total = ($urandom_range(0, 4) == 0) ? $urandom_range(0, slot) :
					$urandom_range(slot + 1, 127);
				case ($urandom_range(0, 9))
					0: d = 32'h0;
					1: d = 32'hFFFF_FFFF;
					default: d = $urandom;
				endcase
				send_pair(p, nb, slot, total, d);
				case ($urandom_range(0, 11))
					0: begin
						c = noise_cmd();
						c.mode = $urandom_range(0, 1) ? MODE_UNKNOWN_A : MODE_UNKNOWN_B;
						send_cmd(c);
					end
					1: write_coef($urandom_range(0, 1) ? rfa_pkg::MODE_ALPHA :
						rfa_pkg::MODE_WEIGHT, 2'($urandom), $urandom_range(0, 7),
						$urandom_range(0, 1) ? rand_alpha() : $urandom);
					default: ;
				endcase
			end
			foreach (parts[i])
				read_clear(parts[i]);
		end
	endtask

	task automatic test_alpha_count_sweep();
		logic [3:0] vals [6] = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd5};
		foreach (vals[i]) begin
			set_alpha_count(vals[i]);
			run_frames(8);
		end
	endtask

	task automatic test_random();
		repeat (3) begin
			set_alpha_count(4'($urandom));
			run_frames(10);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		alpha_count_reg = rfa_pkg::ALPHA_COUNT_RESET;
		foreach (acc_tab[i]) begin
			acc_tab[i] = 0;
			sat_tab[i] = 1'b0;
		end
		foreach (partner_ok[i])
			partner_ok[i] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_coefficients();
		test_directed();
		test_alpha_count_sweep();
		test_random();

		drain(DRAIN_CYCLES);
		if (mismatches == 0 && fingerprint_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: radial_fingerprint_accumulator_core.f
hdl/rfa_pkg.sv
hdl/rfa_ram.sv
hdl/radial_fingerprint_accumulator_core.sv
dv/tb_top.sv
